/* design/qsr_pkg.sv */
`timescale 1ns / 1ps
package qsr_pkg;
    localparam int MaxSymDefault = 24;
    localparam int QW = 16;
    localparam int PW = 35;
    localparam int NW = 71;
    localparam int DW = 53;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ZONE = 2'd1,
        OP_NEAR = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic signed [PW-1:0] w;
    } prod_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    function automatic logic signed [QW-1:0] round_sat(input logic signed [PW-1:0] v);
        logic signed [PW:0] t;
        logic signed [PW-14:0] r;
        begin
            t = {v[PW-1], v} + (PW+1)'(8192);
            r = t[PW:14];
            if (r > (PW-13)'(32767)) round_sat = 16'sh7FFF;
            else if (r < -(PW-13)'(32768)) round_sat = 16'sh8000;
            else round_sat = r[QW-1:0];
        end
    endfunction
endpackage

/* design/qsr_cell.sv */
`timescale 1ns / 1ps
module qsr_cell (
    input  logic                   aclk,
    input  logic                   ld_en,
    input  qsr_pkg::quat_t         ld_q,
    input  logic                   shift,
    input  qsr_pkg::quat_t         nb_q,
    output qsr_pkg::quat_t         q_out
);
    import qsr_pkg::*;
    quat_t q_reg;
    always_ff @(posedge aclk) begin
        if (ld_en) begin
            q_reg <= ld_q;
        end else if (shift) begin
            q_reg <= nb_q;
        end
    end
    assign q_out = q_reg;
endmodule

/* design/qsr_eval.sv */
`timescale 1ns / 1ps
module qsr_eval (
    input  logic                   aclk,
    input  qsr_pkg::quat_t         q,
    input  qsr_pkg::quat_t         s,
    output qsr_pkg::prod_t         p
);
    import qsr_pkg::*;
    logic signed [2*QW-1:0] m_reg [16];
    logic signed [2*QW-1:0] m_next [16];
    function automatic logic signed [2*QW-1:0] mul(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
        mul = (2*QW)'(a) * (2*QW)'(b);
    endfunction
    always_comb begin
        m_next[0] = mul(s.w, q.x); m_next[1] = mul(s.x, q.w); m_next[2] = mul(s.z, q.y);
        m_next[3] = mul(s.y, q.z);
        m_next[4] = mul(s.w, q.y); m_next[5] = mul(s.y, q.w); m_next[6] = mul(s.x, q.z);
        m_next[7] = mul(s.z, q.x);
        m_next[8] = mul(s.w, q.z); m_next[9] = mul(s.z, q.w); m_next[10] = mul(s.y, q.x);
        m_next[11] = mul(s.x, q.y);
        m_next[12] = mul(s.w, q.w); m_next[13] = mul(s.x, q.x); m_next[14] = mul(s.y, q.y);
        m_next[15] = mul(s.z, q.z);
    end
    always_ff @(posedge aclk) begin
        m_reg <= m_next;
    end
    function automatic logic signed [PW-1:0] ext(input logic signed [2*QW-1:0] v);
        ext = PW'(v);
    endfunction
    assign p.x = ext(m_reg[0]) + ext(m_reg[1]) + ext(m_reg[2]) - ext(m_reg[3]);
    assign p.y = ext(m_reg[4]) + ext(m_reg[5]) + ext(m_reg[6]) - ext(m_reg[7]);
    assign p.z = ext(m_reg[8]) + ext(m_reg[9]) + ext(m_reg[10]) - ext(m_reg[11]);
    assign p.w = ext(m_reg[12]) - ext(m_reg[13]) - ext(m_reg[14]) - ext(m_reg[15]);
endmodule

/* design/qsr_score.sv */
`timescale 1ns / 1ps
module qsr_score (
    input  logic                   aclk,
    input  qsr_pkg::prod_t         p,
    input  qsr_pkg::quat_t         rq,
    output qsr_pkg::prod_t         p_out,
    output logic [qsr_pkg::NW-1:0] nrm,
    output logic signed [qsr_pkg::DW-1:0] dot
);
    import qsr_pkg::*;
    prod_t p_reg;
    logic [2*PW-1:0] sq_reg [3];
    logic signed [PW+QW-1:0] dp_reg [4];
    always_ff @(posedge aclk) begin
        p_reg <= p;
        sq_reg[0] <= 70'(p.x * p.x);
        sq_reg[1] <= 70'(p.y * p.y);
        sq_reg[2] <= 70'(p.z * p.z);
        dp_reg[0] <= (PW+QW)'(p.w * rq.w);
        dp_reg[1] <= (PW+QW)'(p.x * rq.x);
        dp_reg[2] <= (PW+QW)'(p.y * rq.y);
        dp_reg[3] <= (PW+QW)'(p.z * rq.z);
    end
    assign p_out = p_reg;
    assign nrm = NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]);
    assign dot = DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]) + DW'(dp_reg[3]);
endmodule

/* design/quaternion_symmetry_reduce_unit.sv */
`timescale 1ns / 1ps
// A query runs until all n symmetry entries are scored and the full ring rotation
// is done, n being num_sym clamped to 1..MAX_SYM; s_ready stays low until the result
// is taken, so a new query waits for the last one; a load does not leave idle.
// The symmetry entries sit in a row of cells that rotates one place a cycle while
// a search runs, feeding a two-stage multiply and score pipeline.
// Reset (aresetn, synchronous, active low) clears control and sets num_sym to 24.
module quaternion_symmetry_reduce_unit #(
    parameter int MAX_SYM = qsr_pkg::MaxSymDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [4:0]  s_sym_index,
    input  logic signed [15:0] s_q_x,
    input  logic signed [15:0] s_q_y,
    input  logic signed [15:0] s_q_z,
    input  logic signed [15:0] s_q_w,
    input  logic signed [15:0] s_ref_x,
    input  logic signed [15:0] s_ref_y,
    input  logic signed [15:0] s_ref_z,
    input  logic signed [15:0] s_ref_w,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_r_x,
    output logic signed [15:0] m_r_y,
    output logic signed [15:0] m_r_z,
    output logic signed [15:0] m_r_w
);
    import qsr_pkg::*;
    localparam int CW = $clog2(MAX_SYM + 4) + 1;

    state_t state_reg, state_next;
    logic [4:0] nsym_reg;
    logic [CW-1:0] cnt_reg, cnt_next, n_eff;
    logic [CW-1:0] rot_reg, rot_next;
    logic near_reg;
    quat_t qin_reg, rq_reg;
    quat_t cq [MAX_SYM];
    logic xfer, shift, rotating;
    prod_t p_e, p_s, best_reg;
    logic [NW-1:0] nrm, bnrm_reg;
    logic signed [DW-1:0] dot, bdot_reg;
    logic take, scoring, first;
    logic signed [15:0] ox_reg, oy_reg, oz_reg, ow_reg;

    assign xfer = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        if (nsym_reg == 5'd0) n_eff = CW'(1);
        else if (32'(nsym_reg) > MAX_SYM) n_eff = CW'(MAX_SYM);
        else n_eff = CW'(nsym_reg);
    end

    // rotate the full ring; restore home position after the search
    assign rotating = (state_reg == ST_RUN) && (rot_reg != '0);
    assign shift = rotating;

    for (genvar i = 0; i < MAX_SYM; i++) begin : g_cell
        logic ld;
        assign ld = xfer && (s_opcode == OP_LOAD) && (s_sym_index == 5'(i))
                    && (32'(s_sym_index) < MAX_SYM);
        qsr_cell u_cell (
            .aclk(aclk), .ld_en(ld),
            .ld_q('{x: s_q_x, y: s_q_y, z: s_q_z, w: s_q_w}),
            .shift(shift), .nb_q(cq[(i + 1) % MAX_SYM]), .q_out(cq[i])
        );
    end

    qsr_eval u_eval (.aclk(aclk), .q(qin_reg), .s(cq[0]), .p(p_e));
    qsr_score u_score (.aclk(aclk), .p(p_e), .rq(rq_reg),
        .p_out(p_s), .nrm(nrm), .dot(dot));

    // cnt counts cycles in RUN; entry k reaches the score stage at cnt = k + 2
    assign scoring = (state_reg == ST_RUN) && (cnt_reg >= CW'(2))
                     && (cnt_reg < n_eff + CW'(2));
    assign first = (cnt_reg == CW'(2));
    assign take = first || (near_reg ? (dot > bdot_reg) : (nrm < bnrm_reg));

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rot_next = rot_reg;
        case (state_reg)
            ST_IDLE: begin
                if (xfer && (s_opcode == OP_ZONE || s_opcode == OP_NEAR)) begin
                    state_next = ST_RUN;
                    cnt_next = '0;
                    rot_next = CW'(MAX_SYM);
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + CW'(1);
                if (rot_reg != '0) rot_next = rot_reg - CW'(1);
                if (cnt_reg >= n_eff + CW'(2) && rot_reg <= CW'(1)) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nsym_reg <= 5'd24;
            cnt_reg <= '0;
            rot_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rot_reg <= rot_next;
            if (cfg_we) nsym_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            qin_reg <= '{x: s_q_x, y: s_q_y, z: s_q_z, w: s_q_w};
            rq_reg <= '{x: s_ref_x, y: s_ref_y, z: s_ref_z, w: s_ref_w};
            near_reg <= (s_opcode == OP_NEAR);
        end
        if (scoring && take) begin
            best_reg <= p_s;
            bnrm_reg <= nrm;
            bdot_reg <= dot;
        end
        if (state_reg == ST_RUN && state_next == ST_OUT) begin
            if (best_reg.w < 0) begin
                ox_reg <= round_sat(-best_reg.x);
                oy_reg <= round_sat(-best_reg.y);
                oz_reg <= round_sat(-best_reg.z);
                ow_reg <= round_sat(-best_reg.w);
            end else begin
                ox_reg <= round_sat(best_reg.x);
                oy_reg <= round_sat(best_reg.y);
                oz_reg <= round_sat(best_reg.z);
                ow_reg <= round_sat(best_reg.w);
            end
        end
    end

    assign m_valid = (state_reg == ST_OUT);
    assign m_r_x = ox_reg;
    assign m_r_y = oy_reg;
    assign m_r_z = oz_reg;
    assign m_r_w = ow_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready during result");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r_x) && $stable(m_r_w))
        else $error("result dropped");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && (s_opcode == OP_ZONE || s_opcode == OP_NEAR) |=> state_reg == ST_RUN)
        else $error("query not started");
endmodule
